// ----- hdl/mrf_pkg.sv -----
// Shared types, codes and CRC helper for the Modbus RTU request framer.
// No dependencies; used by mrf_frame_seq and modbus_rtu_request_framer.
package mrf_pkg;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_DATA  = 2'd2
  } func_t;

  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam int          TMO_W           = 23;

  typedef struct packed {
    logic [7:0]       data;
    logic             net;
    logic             last;
    logic [TMO_W-1:0] timeout;
  } mrf_byte_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- hdl/mrf_frame_seq.sv -----
// Item register and byte sequencer: turns one header or data word into frame bytes,
// one per cycle while byte_ready is high, tracking CRC and write progress. Depends on mrf_pkg.
module mrf_frame_seq import mrf_pkg::*; #(
  parameter int MAX_REGS = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] packet_time,
  input  logic        in_valid,
  output logic        in_ready,
  input  func_t       in_func,
  input  logic        in_net,
  input  logic [7:0]  in_slave_id,
  input  logic [16:0] in_start_addr,
  input  logic [6:0]  in_count,
  input  logic [15:0] in_reg_value,
  output logic        byte_valid,
  input  logic        byte_ready,
  output mrf_byte_t   byte_o
);

  localparam logic [6:0] MAX_CNT = 7'(MAX_REGS);

  logic        item_vld_r;
  func_t       func_r;
  logic        net_r;
  logic [7:0]  slave_r;
  logic [15:0] waddr_r;
  logic [6:0]  cnt_r;
  logic [15:0] value_r;
  logic [6:0]  pk3_r;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_acc_r, crc_acc_nxt;
  logic [6:0]  words_left_r, words_left_nxt;
  logic        write_active_r, write_active_nxt;
  logic        frame_net_r, frame_net_nxt;

  logic [6:0]  cnt_c;
  logic [8:0]  pk_sum;
  logic [5:0]  pk;
  logic        is_hdr, is_rd, is_dat;
  logic [3:0]  nbytes;
  logic        btake, item_done, accept;
  logic        is_crc_lo, is_crc_hi;
  logic [7:0]  data_byte;
  logic [15:0] crc_cur;
  logic [22:0] tmo_rd, tmo_wr;

  assign cnt_c  = (in_count > MAX_CNT) ? MAX_CNT : in_count;
  assign pk_sum = 9'd5 + {1'b0, cnt_c, 1'b0};
  assign pk     = 6'(pk_sum[8:3]) + 6'd1;

  assign is_rd  = (func_r == FUNC_READ);
  assign is_hdr = is_rd || (func_r == FUNC_WRITE);
  assign is_dat = (func_r == FUNC_DATA);

  always_comb begin
    nbytes = 4'd0;
    if (is_rd) begin
      nbytes = 4'd8;
    end else if (is_hdr) begin
      nbytes = (cnt_r == 7'd0) ? 4'd9 : 4'd7;
    end else if (is_dat && write_active_r) begin
      nbytes = (words_left_r == 7'd1) ? 4'd4 : 4'd2;
    end
  end

  assign byte_valid = item_vld_r && (nbytes != 4'd0);
  assign btake      = byte_valid && byte_ready;
  assign item_done  = item_vld_r && ((nbytes == 4'd0) || (btake && (idx_r == nbytes - 4'd1)));
  assign in_ready   = !item_vld_r || item_done;
  assign accept     = in_valid && in_ready;

  always_comb begin
    data_byte = 8'h00;
    is_crc_lo = 1'b0;
    is_crc_hi = 1'b0;
    if (is_hdr) begin
      case (idx_r)
        4'd0: data_byte = slave_r;
        4'd1: data_byte = is_rd ? FC_READ_HOLDING : FC_WRITE_MULTI;
        4'd2: data_byte = waddr_r[15:8];
        4'd3: data_byte = waddr_r[7:0];
        4'd4: data_byte = 8'h00;
        4'd5: data_byte = {1'b0, cnt_r};
        4'd6: begin
          data_byte = {cnt_r, 1'b0};
          is_crc_lo = is_rd;
        end
        4'd7: begin
          is_crc_lo = !is_rd;
          is_crc_hi = is_rd;
        end
        4'd8: is_crc_hi = 1'b1;
        default: data_byte = 8'h00;
      endcase
    end else begin
      case (idx_r)
        4'd0: data_byte = value_r[15:8];
        4'd1: data_byte = value_r[7:0];
        4'd2: is_crc_lo = 1'b1;
        4'd3: is_crc_hi = 1'b1;
        default: data_byte = 8'h00;
      endcase
    end
  end

  assign crc_cur = (is_hdr && (idx_r == 4'd0)) ? CRC_INIT : crc_acc_r;
  assign tmo_rd  = 23'(pk3_r) * 23'(packet_time);
  assign tmo_wr  = {6'd0, packet_time, 1'b0};

  always_comb begin
    byte_o.net  = is_hdr ? net_r : frame_net_r;
    byte_o.last = is_crc_hi;
    if (is_crc_lo) begin
      byte_o.data = crc_cur[7:0];
    end else if (is_crc_hi) begin
      byte_o.data = crc_acc_r[15:8];
    end else begin
      byte_o.data = data_byte;
    end
    if (is_crc_hi) begin
      byte_o.timeout = is_rd ? tmo_rd : tmo_wr;
    end else begin
      byte_o.timeout = '0;
    end
  end

  always_comb begin
    idx_nxt          = idx_r;
    crc_acc_nxt      = crc_acc_r;
    words_left_nxt   = words_left_r;
    write_active_nxt = write_active_r;
    frame_net_nxt    = frame_net_r;
    if (btake) begin
      idx_nxt = idx_r + 4'd1;
      if (is_crc_hi) begin
        crc_acc_nxt = CRC_INIT;
      end else if (!is_crc_lo) begin
        crc_acc_nxt = crc_byte(crc_cur, data_byte);
      end
    end
    if (item_done) begin
      idx_nxt = 4'd0;
      if (is_hdr) begin
        frame_net_nxt    = net_r;
        write_active_nxt = !is_rd && (cnt_r != 7'd0);
        words_left_nxt   = is_rd ? 7'd0 : cnt_r;
      end else if (is_dat && write_active_r) begin
        words_left_nxt   = words_left_r - 7'd1;
        write_active_nxt = (words_left_r != 7'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r     <= 1'b0;
      idx_r          <= 4'd0;
      crc_acc_r      <= CRC_INIT;
      words_left_r   <= 7'd0;
      write_active_r <= 1'b0;
      frame_net_r    <= 1'b0;
    end else begin
      if (accept) begin
        item_vld_r <= 1'b1;
      end else if (item_done) begin
        item_vld_r <= 1'b0;
      end
      idx_r          <= idx_nxt;
      crc_acc_r      <= crc_acc_nxt;
      words_left_r   <= words_left_nxt;
      write_active_r <= write_active_nxt;
      frame_net_r    <= frame_net_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      net_r   <= in_net;
      slave_r <= in_slave_id;
      waddr_r <= in_start_addr[15:0] - 16'd1;
      cnt_r   <= cnt_c;
      value_r <= in_reg_value;
      pk3_r   <= {pk, 1'b0} + {1'b0, pk};
    end
  end

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_vld_r |-> (idx_r < 4'd9))
    else $error("byte index past end of frame");
  a_active_has_words: assert property (@(posedge clk) disable iff (!rst_n)
    write_active_r |-> (words_left_r != 7'd0))
    else $error("write in progress with no words left");
  a_idle_no_words: assert property (@(posedge clk) disable iff (!rst_n)
    !write_active_r |-> (words_left_r == 7'd0))
    else $error("words left without a write in progress");
  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (btake && is_crc_hi) |=> (crc_acc_r == CRC_INIT))
    else $error("CRC not restarted after frame end");
  a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (item_done && !accept) |=> !item_vld_r)
    else $error("item register not freed after last byte");
`endif

endmodule

// ----- hdl/modbus_rtu_request_framer.sv -----
// Modbus RTU request framer top level: stream ports, packet_time register and
// output register stage. Depends on mrf_pkg and mrf_frame_seq.
//
// Usage:
//   in_*  : one word per header (read or write) or per register data word.
//   out_* : the frame bytes of each word, in send order; out_tlast marks the final
//           CRC byte, which also carries the reply timeout in out_tdata[30:8].
//   cfg_* : write cfg_wr_data to packet_time whenever cfg_wr_en is high.
// Path: an accepted item waits in the item register, and its bytes pass through
//   the output register to out_*.
// Throughput: one byte per cycle while out_tready allows. A read header yields 8
//   bytes, a write header 7 (9 when count is 0), a data word 2 (4 for the final word),
//   and an ignored word none; the byte sequencer emits one byte per cycle when not stalled.
//   The next item is taken in the cycle its predecessor's last byte leaves.
// Reset: packet_time returns to 10, no frame is in progress, CRC reinitialized.
// Stall: when out_tready is low the output register holds its byte, the
//   sequencer holds, and in_tready drops once the item register is occupied.
module modbus_rtu_request_framer import mrf_pkg::*; #(
  parameter int MAX_REGS = 127
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // packet_time
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,       // slave_id[7:0], start_addr[24:8], count[31:25],
                                      // reg_value[47:32]
  input  logic [2:0]  in_tuser,       // func[1:0], net[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // frame_byte[7:0], reply_timeout[30:8], zero[31]
  output logic        out_tuser,      // out_net
  output logic        out_tlast       // last_byte
);

  logic [15:0] packet_time_r;
  logic        out_vld_r;
  mrf_byte_t   out_byte_r;
  logic        byte_valid, byte_ready;
  mrf_byte_t   seq_byte;

  mrf_frame_seq #(
    .MAX_REGS(MAX_REGS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .packet_time  (packet_time_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_func      (func_t'(in_tuser[1:0])),
    .in_net       (in_tuser[2]),
    .in_slave_id  (in_tdata[7:0]),
    .in_start_addr(in_tdata[24:8]),
    .in_count     (in_tdata[31:25]),
    .in_reg_value (in_tdata[47:32]),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_o       (seq_byte)
  );

  assign byte_ready = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      packet_time_r <= 16'd10;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        packet_time_r <= cfg_wr_data;
      end
      if (byte_ready) begin
        out_vld_r <= byte_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      out_byte_r <= seq_byte;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_byte_r.timeout, out_byte_r.data};
  assign out_tuser  = out_byte_r.net;
  assign out_tlast  = out_byte_r.last;

endmodule
